[rtl/rsa_modular_exponentiation_defines.svh]
// Assertion macros shared by the modular exponentiation RTL.
`ifndef RSA_MODULAR_EXPONENTIATION_DEFINES_SVH
`define RSA_MODULAR_EXPONENTIATION_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off during reset.
`define RME_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, sampled on clk, off during reset.
`define RME_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define RME_ASSERT_IMP(lbl, ante, cons, msg)
`define RME_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

[rtl/rme_pkg.sv]
// Shared types and constants for the modular exponentiation block.
package rme_pkg;

	localparam int unsigned CFG_W = 32;
	localparam int unsigned OFF_W = 8;
	localparam int unsigned RES_W = 33;

	// reset values of the configuration registers
	localparam logic [CFG_W-1:0] RST_MODULUS  = 32'd2;
	localparam logic [CFG_W-1:0] RST_PUB_EXP  = 32'd1;
	localparam logic [CFG_W-1:0] RST_PRIV_EXP = 32'd1;
	localparam logic [OFF_W-1:0] RST_OFFSET   = 8'd97;

	localparam logic KIND_DECRYPT = 1'b1;

	typedef enum logic [1:0] {
		REG_MODULUS  = 2'd0,
		REG_PUB_EXP  = 2'd1,
		REG_PRIV_EXP = 2'd2,
		REG_CHAR_OFF = 2'd3
	} reg_idx_t;

	// operand selection for the modular multiplier
	typedef enum logic [1:0] {
		MSEL_RED = 2'd0,
		MSEL_ACC = 2'd1,
		MSEL_SQR = 2'd2
	} msel_t;

	typedef struct packed {
		logic  load;
		logic  mul_start;
		msel_t mul_sel;
		logic  wr_red;
		logic  wr_acc;
		logic  wr_sqr;
		logic  out_load;
	} cmd_t;

	typedef struct packed {
		logic mul_busy;
		logic mul_done;
		logic degenerate;
		logic ex_zero;
		logic ex_lsb;
	} sts_t;

endpackage

[rtl/rme_modmul.sv]
// Bit-serial interleaved modular multiplier: a*b mod n, one bit of b per cycle.
module rme_modmul
	import rme_pkg::*;
#(
	parameter int unsigned WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [WIDTH-1:0] a,
	input  logic [WIDTH-1:0] b,
	input  logic [WIDTH-1:0] n,
	output logic             busy,
	output logic             done,
	output logic [WIDTH-1:0] prod
);

	localparam int unsigned CNT_W = $clog2(WIDTH);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WIDTH - 1);

	logic [WIDTH-1:0] acc_q;
	logic [WIDTH-1:0] a_q;
	logic [WIDTH-1:0] b_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [WIDTH:0] n_ext;
	logic [WIDTH:0] dbl;
	logic [WIDTH:0] dbl_red;
	logic [WIDTH:0] sum;
	logic [WIDTH:0] sum_red;

	// acc = 2*acc + bit*a, each term folded back below n
	always_comb begin
		n_ext   = {1'b0, n};
		dbl     = {acc_q, 1'b0};
		dbl_red = (dbl >= n_ext) ? (dbl - n_ext) : dbl;
		sum     = dbl_red + (b_q[WIDTH-1] ? {1'b0, a_q} : '0);
		sum_red = (sum >= n_ext) ? (sum - n_ext) : sum;
	end

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// operand and partial-result registers
	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			acc_q <= '0;
			a_q   <= a;
			b_q   <= b;
		end else if (busy_q) begin
			acc_q <= sum_red[WIDTH-1:0];
			b_q   <= {b_q[WIDTH-2:0], 1'b0};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign prod = acc_q;

endmodule

[rtl/rme_datapath.sv]
// Datapath: operand registers, base reduction, square-and-multiply registers, result.
module rme_datapath
	import rme_pkg::*;
#(
	parameter int unsigned WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             kind,
	input  logic [CFG_W-1:0] value,
	input  logic [CFG_W-1:0] modulus,
	input  logic [CFG_W-1:0] pub_exp,
	input  logic [CFG_W-1:0] priv_exp,
	input  logic [OFF_W-1:0] char_off,
	input  cmd_t             cmd,
	output sts_t             sts,
	output logic [RES_W-1:0] result
);

	logic             kind_q;
	logic [WIDTH-1:0] v_q;
	logic [WIDTH-1:0] n_q;
	logic [WIDTH-1:0] ex_q;
	logic [OFF_W-1:0] off_q;
	logic [WIDTH-1:0] acc_q;
	logic [WIDTH-1:0] base_q;
	logic [RES_W-1:0] res_q;

	logic [WIDTH-1:0] off_w;
	logic             below_off;
	logic [WIDTH-1:0] red_op;
	logic [WIDTH-1:0] mul_a;
	logic [WIDTH-1:0] mul_b;
	logic [WIDTH-1:0] prod;
	logic [WIDTH-1:0] red_fix;
	logic [WIDTH-1:0] pow;
	logic [RES_W-1:0] res_next;
	logic             mul_busy;
	logic             mul_done;
	logic             degenerate;

	assign off_w      = WIDTH'(off_q);
	assign below_off  = (v_q < off_w);
	assign degenerate = (n_q < WIDTH'(2));

	// value to be reduced mod n before the power loop
	always_comb begin
		if (kind_q == KIND_DECRYPT) begin
			red_op = v_q;
		end else if (below_off) begin
			red_op = off_w - v_q;
		end else begin
			red_op = v_q - off_w;
		end
	end

	// multiplier operand select
	always_comb begin
		unique case (cmd.mul_sel)
			MSEL_RED: begin
				mul_a = WIDTH'(1);
				mul_b = red_op;
			end
			MSEL_ACC: begin
				mul_a = acc_q;
				mul_b = base_q;
			end
			default: begin
				mul_a = base_q;
				mul_b = base_q;
			end
		endcase
	end

	rme_modmul #(
		.WIDTH(WIDTH)
	) u_modmul (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.mul_start),
		.a     (mul_a),
		.b     (mul_b),
		.n     (n_q),
		.busy  (mul_busy),
		.done  (mul_done),
		.prod  (prod)
	);

	// a code below the offset gives a negative difference: take n minus its residue
	always_comb begin
		if ((kind_q != KIND_DECRYPT) && below_off && (prod != '0)) begin
			red_fix = n_q - prod;
		end else begin
			red_fix = prod;
		end
	end

	// final word: power (zero for a modulus below 2), plus the offset on decrypt
	always_comb begin
		pow      = degenerate ? '0 : acc_q;
		res_next = RES_W'(pow) + ((kind_q == KIND_DECRYPT) ? RES_W'(off_q) : '0);
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= kind;
			v_q    <= value[WIDTH-1:0];
			n_q    <= modulus[WIDTH-1:0];
			ex_q   <= (kind == KIND_DECRYPT) ? priv_exp[WIDTH-1:0] : pub_exp[WIDTH-1:0];
			off_q  <= char_off;
			acc_q  <= WIDTH'(1);
		end
		if (cmd.wr_red) begin
			base_q <= red_fix;
		end
		if (cmd.wr_sqr) begin
			base_q <= prod;
			ex_q   <= ex_q >> 1;
		end
		if (cmd.wr_acc) begin
			acc_q <= prod;
		end
		if (cmd.out_load) begin
			res_q <= res_next;
		end
	end

	assign sts.mul_busy   = mul_busy;
	assign sts.mul_done   = mul_done;
	assign sts.degenerate = degenerate;
	assign sts.ex_zero    = (ex_q == '0);
	assign sts.ex_lsb     = ex_q[0];
	assign result         = res_q;

endmodule

[rtl/rme_ctrl.sv]
// Controller: sequences reduction, square-and-multiply and the output word.
`include "rsa_modular_exponentiation_defines.svh"
module rme_ctrl
	import rme_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic item_valid,
	output logic item_stall,
	output logic result_valid,
	input  logic result_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_PREP   = 7'b0000010,
		ST_RED    = 7'b0000100,
		ST_LOOP   = 7'b0001000,
		ST_MACC   = 7'b0010000,
		ST_MSQR   = 7'b0100000,
		ST_FINISH = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.mul_sel = MSEL_SQR;
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_PREP;
				end
			end
			ST_PREP: begin
				if (sts.degenerate) begin
					state_d = ST_FINISH;
				end else begin
					cmd.mul_start = 1'b1;
					cmd.mul_sel   = MSEL_RED;
					state_d       = ST_RED;
				end
			end
			ST_RED: begin
				if (sts.mul_done) begin
					cmd.wr_red = 1'b1;
					state_d    = ST_LOOP;
				end
			end
			ST_LOOP: begin
				if (sts.ex_zero) begin
					state_d = ST_FINISH;
				end else if (sts.ex_lsb) begin
					cmd.mul_start = 1'b1;
					cmd.mul_sel   = MSEL_ACC;
					state_d       = ST_MACC;
				end else begin
					cmd.mul_start = 1'b1;
					state_d       = ST_MSQR;
				end
			end
			ST_MACC: begin
				if (sts.mul_done) begin
					cmd.wr_acc    = 1'b1;
					cmd.mul_start = 1'b1;
					state_d       = ST_MSQR;
				end
			end
			ST_MSQR: begin
				if (sts.mul_done) begin
					cmd.wr_sqr = 1'b1;
					state_d    = ST_LOOP;
				end
			end
			ST_FINISH: begin
				if (!out_valid_q || !result_stall) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// output word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign item_stall   = (state_q != ST_IDLE);
	assign result_valid = out_valid_q;

	`RME_ASSERT_IMP(a_start_free, cmd.mul_start, !sts.mul_busy, "multiply started while busy")
	`RME_ASSERT_IMP(a_wr_on_done, cmd.wr_red || cmd.wr_acc || cmd.wr_sqr, sts.mul_done, "product written before done")
	`RME_ASSERT_IMP(a_no_overwrite, cmd.out_load, !(out_valid_q && result_stall), "pending word overwritten")
	`RME_ASSERT_NXT(a_busy_after_take, item_valid && !item_stall, item_stall, "second word taken while busy")

endmodule

[rtl/rsa_modular_exponentiation.sv]
// Top level: configuration registers, controller and datapath of the RSA power unit.
//
// Usage:
//   Configuration goes through the APB-style port: modulus at 0x0, public exponent at
//   0x4, private exponent at 0x8, character offset at 0xC. pready is always high.
//   Write registers only while no word is in flight.
//   Input words (kind, value) are taken when item_valid is high and item_stall low.
//   kind 0 encrypts (value minus offset, wrapped mod n, raised to e); kind 1
//   decrypts (value raised to d mod n, plus offset). One result word per input.
//   Each modular multiply is bit-serial. The power loop does one square per exponent
//   bit and one more multiply per one bit of the exponent. The result shows up, and the
//   next word can be taken, once the loop ends and the word is loaded; a modulus below
//   2 skips the reduction and the loop.
//   The multiplier is the bottleneck; one item is in work at a time.
//   The finished word sits in an output register: a new input word is taken while it
//   waits under result_stall; the next result waits until it is taken.
//   Reset clears control and restores the register defaults (n 2, e 1, d 1, offset 97).
module rsa_modular_exponentiation
	import rme_pkg::*;
#(
	parameter int unsigned WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [3:0]       paddr,
	input  logic [CFG_W-1:0] pwdata,
	output logic [CFG_W-1:0] prdata,
	output logic             pready,
	input  logic             item_valid,
	output logic             item_stall,
	input  logic             kind,
	input  logic [CFG_W-1:0] value,
	output logic             result_valid,
	input  logic             result_stall,
	output logic [RES_W-1:0] result
);

	logic [CFG_W-1:0] modulus_q;
	logic [CFG_W-1:0] pub_exp_q;
	logic [CFG_W-1:0] priv_exp_q;
	logic [OFF_W-1:0] char_off_q;

	reg_idx_t reg_idx;
	logic     cfg_wr;
	cmd_t     cmd;
	sts_t     sts;

	assign reg_idx = reg_idx_t'(paddr[3:2]);
	assign cfg_wr  = psel && penable && pwrite;
	assign pready  = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q  <= RST_MODULUS;
			pub_exp_q  <= RST_PUB_EXP;
			priv_exp_q <= RST_PRIV_EXP;
			char_off_q <= RST_OFFSET;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_MODULUS:  modulus_q  <= pwdata;
				REG_PUB_EXP:  pub_exp_q  <= pwdata;
				REG_PRIV_EXP: priv_exp_q <= pwdata;
				default:      char_off_q <= pwdata[OFF_W-1:0];
			endcase
		end
	end

	// read back
	always_comb begin
		unique case (reg_idx)
			REG_MODULUS:  prdata = modulus_q;
			REG_PUB_EXP:  prdata = pub_exp_q;
			REG_PRIV_EXP: prdata = priv_exp_q;
			default:      prdata = CFG_W'(char_off_q);
		endcase
	end

	rme_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.sts         (sts),
		.cmd         (cmd)
	);

	rme_datapath #(
		.WIDTH(WIDTH)
	) u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.kind    (kind),
		.value   (value),
		.modulus (modulus_q),
		.pub_exp (pub_exp_q),
		.priv_exp(priv_exp_q),
		.char_off(char_off_q),
		.cmd     (cmd),
		.sts     (sts),
		.result  (result)
	);

endmodule
